// ----- src/utf8_cjk_text_cleaner_assert.svh -----
// Assertion macros for the cleaner RTL.
`ifndef UTF8_CJK_TEXT_CLEANER_ASSERT_SVH
`define UTF8_CJK_TEXT_CLEANER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UCJK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8_cjk_text_cleaner: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UCJK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8_cjk_text_cleaner: check failed");

`endif

// ----- src/ucjk_pkg.sv -----
`timescale 1ns / 1ps

package ucjk_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_done;
    logic       last_of_run;
  } out_item_t;

  // Results of one input byte: up to four data bytes, then an optional terminator.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n_data;
    logic            term;
  } bundle_t;

  localparam logic [7:0] SpaceByte   = 8'h20;
  localparam logic [7:0] CjkLeadLo   = 8'hE4;
  localparam logic [7:0] CjkLeadHi   = 8'hE9;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [7:0] PunctLeadE3 = 8'hE3;
  localparam logic [7:0] PunctLeadEf = 8'hEF;
  localparam logic [7:0] PunctLeadE2 = 8'hE2;
  localparam logic [7:0] PunctMid80  = 8'h80;
  localparam logic [7:0] PunctMidBc  = 8'hBC;
  localparam logic [7:0] PunctMidB8  = 8'hB8;
  localparam logic [7:0] PunctLo80   = 8'h80;
  localparam logic [7:0] PunctLo90   = 8'h90;
  localparam logic [7:0] PunctLoB0   = 8'hB0;
  localparam logic [7:0] PunctHiBf   = 8'hBF;

endpackage

// ----- src/ucjk_front.sv -----
`timescale 1ns / 1ps

module ucjk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ucjk_pkg::in_item_t item,
  output logic              push,
  output ucjk_pkg::bundle_t bundle
);

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            sp;
    logic            em;
    logic [1:0]      sk;
  } work_t;

  logic [7:0] win0_r, win1_r, win0_nxt, win1_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic [1:0] skip_r, skip_nxt;
  logic       space_r, space_nxt;
  logic       emitted_r, emitted_nxt;
  work_t      w;

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic is_cjk(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return a >= ucjk_pkg::CjkLeadLo && a <= ucjk_pkg::CjkLeadHi &&
           (b & ucjk_pkg::ContMask) == ucjk_pkg::ContTag &&
           (c & ucjk_pkg::ContMask) == ucjk_pkg::ContTag;
  endfunction

  function automatic logic is_cjk_punct(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic hi_ok;
    hi_ok = (c <= ucjk_pkg::PunctHiBf);
    return (a == ucjk_pkg::PunctLeadE3 && b == ucjk_pkg::PunctMid80 &&
            c >= ucjk_pkg::PunctLo80 && hi_ok) ||
           (a == ucjk_pkg::PunctLeadEf && b == ucjk_pkg::PunctMidBc &&
            c >= ucjk_pkg::PunctLo80 && hi_ok) ||
           (a == ucjk_pkg::PunctLeadE2 && b == ucjk_pkg::PunctMid80 &&
            c >= ucjk_pkg::PunctLo90 && hi_ok) ||
           (a == ucjk_pkg::PunctLeadEf && b == ucjk_pkg::PunctMidB8 &&
            c >= ucjk_pkg::PunctLoB0 && hi_ok);
  endfunction

  // Append a kept byte, preceded by a pending space if there is one.
  function automatic work_t give_byte(work_t x, logic [7:0] v);
    work_t r;
    r = x;
    if (r.sp) begin
      r.data[r.cnt[1:0]] = ucjk_pkg::SpaceByte;
      r.cnt              = r.cnt + 3'd1;
      r.sp               = 1'b0;
    end
    r.data[r.cnt[1:0]] = v;
    r.cnt              = r.cnt + 3'd1;
    r.em               = 1'b1;
    return r;
  endfunction

  function automatic work_t give_sep(work_t x);
    work_t r;
    r = x;
    if (r.em) r.sp = 1'b1;
    return r;
  endfunction

  function automatic work_t classify_full(work_t x, logic [7:0] a, logic [7:0] b,
                                          logic [7:0] c);
    work_t r;
    r = x;
    priority if (r.sk != 2'd0) begin
      r.sk = r.sk - 2'd1;
    end else if (is_cjk(a, b, c)) begin
      r    = give_byte(r, a);
      r    = give_byte(r, b);
      r    = give_byte(r, c);
      r.sk = 2'd2;
    end else if (is_alnum(a)) begin
      r = give_byte(r, a);
    end else if (is_cjk_punct(a, b, c)) begin
      r    = give_sep(r);
      r.sk = 2'd2;
    end else if (is_punct(a)) begin
      r = give_sep(r);
    end else begin
      // any other byte is dropped alone
    end
    return r;
  endfunction

  function automatic work_t classify_tail(work_t x, logic [7:0] a);
    work_t r;
    r = x;
    priority if (r.sk != 2'd0) begin
      r.sk = r.sk - 2'd1;
    end else if (is_alnum(a)) begin
      r = give_byte(r, a);
    end else if (is_punct(a)) begin
      r = give_sep(r);
    end else begin
      // any other byte is dropped alone
    end
    return r;
  endfunction

  always_comb begin
    w.data   = '0;
    w.cnt    = 3'd0;
    w.sp     = space_r;
    w.em     = emitted_r;
    w.sk     = skip_r;
    win0_nxt = win0_r;
    win1_nxt = win1_r;
    fill_nxt = fill_r;
    if (fill_r[1]) begin
      w        = classify_full(w, win0_r, win1_r, item.data_byte);
      win0_nxt = win1_r;
      win1_nxt = item.data_byte;
    end else if (fill_r == 2'd0) begin
      win0_nxt = item.data_byte;
      fill_nxt = 2'd1;
    end else begin
      win1_nxt = item.data_byte;
      fill_nxt = 2'd2;
    end
    if (item.end_of_text) begin
      w = classify_tail(w, win0_nxt);
      if (fill_nxt == 2'd2) w = classify_tail(w, win1_nxt);
    end
    skip_nxt    = w.sk;
    space_nxt   = w.sp;
    emitted_nxt = w.em;
  end

  assign push          = accept && (w.cnt != 3'd0 || item.end_of_text);
  assign bundle.data   = w.data;
  assign bundle.n_data = w.cnt;
  assign bundle.term   = item.end_of_text;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r    <= '0;
      win1_r    <= '0;
      fill_r    <= '0;
      skip_r    <= '0;
      space_r   <= 1'b0;
      emitted_r <= 1'b0;
    end else if (accept) begin
      if (item.end_of_text) begin
        win0_r    <= '0;
        win1_r    <= '0;
        fill_r    <= '0;
        skip_r    <= '0;
        space_r   <= 1'b0;
        emitted_r <= 1'b0;
      end else begin
        win0_r    <= win0_nxt;
        win1_r    <= win1_nxt;
        fill_r    <= fill_nxt;
        skip_r    <= skip_nxt;
        space_r   <= space_nxt;
        emitted_r <= emitted_nxt;
      end
    end
  end

endmodule

// ----- src/ucjk_queue.sv -----
`timescale 1ns / 1ps

module ucjk_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ucjk_pkg::bundle_t push_data,
  input  logic              pop,
  output ucjk_pkg::bundle_t pop_data,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ucjk_pkg::bundle_t slot_r [DEPTH];
  logic [PtrW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign pop_data = slot_r[head_r];
  assign full     = (cnt_r == FullCnt);
  assign empty    = (cnt_r == '0);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == LastPtr) ? '0 : tail_r + PtrW'(1);
    end
    if (pop) begin
      head_nxt = (head_r == LastPtr) ? '0 : head_r + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[tail_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- src/ucjk_back.sv -----
`timescale 1ns / 1ps

module ucjk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ucjk_pkg::bundle_t   pop_data,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ucjk_pkg::out_item_t out_data
);

  ucjk_pkg::bundle_t   cur_r;
  logic                cur_v_r;
  logic [2:0]          idx_r;
  logic                out_v_r;
  ucjk_pkg::out_item_t out_r;
  ucjk_pkg::out_item_t ent;
  logic [2:0]          total;
  logic                adv, emit, last, take;

  assign total = cur_r.n_data + {2'b00, cur_r.term};
  assign last  = (idx_r == total - 3'd1);
  assign adv   = !out_v_r || !out_stall;
  assign emit  = adv && cur_v_r;
  assign take  = !q_empty && (!cur_v_r || (emit && last));
  assign pop   = take;

  always_comb begin
    if (idx_r < cur_r.n_data) begin
      ent.out_byte   = cur_r.data[idx_r[1:0]];
      ent.byte_valid = 1'b1;
      ent.text_done  = 1'b0;
    end else begin
      ent.out_byte   = 8'h00;
      ent.byte_valid = 1'b0;
      ent.text_done  = 1'b1;
    end
    ent.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= pop_data;
    end
    if (emit) begin
      out_r <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        cur_v_r <= 1'b1;
        idx_r   <= '0;
      end else if (emit && last) begin
        cur_v_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (adv) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- src/utf8_cjk_text_cleaner.sv -----
// utf8_cjk_text_cleaner: byte-serial UTF-8 cleaner ahead of an indexer.
// Input channel (in_valid / in_stall / in_data): one raw text byte per
// transaction, end_of_text set on the last byte of a text.
// Output channel (out_valid / out_stall / out_data): one result per
// transaction; kept bytes and collapsed 0x20 separators carry byte_valid,
// the closing terminator carries text_done, last_of_run marks the final
// result caused by one input byte.
// Front stage: three-byte window classifier; each accepted byte that yields
// results pushes a bundle of up to five results into a small queue.
// Back stage: walks a bundle one result per cycle into the output register.
// A byte's results are held in a queue slot, then in the current bundle.
// Throughput: one input byte per cycle while the queue has room, one
// result per cycle on the output while out_stall is low; the back stage sets
// the sustained rate (a byte occupies it while it has results, up to five).
// Reset (rst_n low, synchronous) empties the queue and output register and
// clears the window, so the next byte starts a new text.
// While out_stall is high the output holds; the queue fills and then
// in_stall rises until the back stage drains a bundle.
`timescale 1ns / 1ps
`include "utf8_cjk_text_cleaner_assert.svh"

module utf8_cjk_text_cleaner #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ucjk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ucjk_pkg::out_item_t out_data
);

  logic              in_take;
  logic              q_push, q_pop, q_full, q_empty;
  ucjk_pkg::bundle_t q_wdata, q_rdata;

  // Stall only on a full queue: the check does not ask whether the byte yields
  // any results, so it is conservative and independent of data.
  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  ucjk_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_take),
    .item   (in_data),
    .push   (q_push),
    .bundle (q_wdata)
  );

  ucjk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  ucjk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (q_rdata),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Terminator is always the final, data-less result of its byte.
  `UCJK_ASSERT_IMP(a_term_last, clk, rst_n, out_valid && out_data.text_done, out_data.last_of_run && !out_data.byte_valid)
  // Every result is either a byte or a terminator, never both or neither.
  `UCJK_ASSERT_IMP(a_kind, clk, rst_n, out_valid, out_data.byte_valid != out_data.text_done)
  // Queue is never written full or read empty.
  `UCJK_ASSERT_IMP(a_no_ovf, clk, rst_n, q_push, !q_full)
  `UCJK_ASSERT_IMP(a_no_udf, clk, rst_n, q_pop, !q_empty)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // Watchdog: longest legal quiet stretch is the forced output hold-off plus
  // a sender gap; take it many times over.
  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 80;
  // Drain wait after the last result, generous against the block's latency.
  localparam int DrainCycles = 20;
  localparam int RandBytes   = 200;

  localparam ucjk_pkg::out_item_t TermOnly = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam ucjk_pkg::out_item_t NoResult = '0;

  // One row of the directed table. If hand_typed is set, the row carries its
  // own expected outcome (none, or the single result in res). Otherwise the
  // predictor supplies it.
  typedef struct packed {
    ucjk_pkg::in_item_t  item;
    logic                hand_typed;
    logic                one_res;
    ucjk_pkg::out_item_t res;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ucjk_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ucjk_pkg::out_item_t out_data;

  utf8_cjk_text_cleaner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Predictor state. It mirrors the block's window, the skip count of the
  // three-byte match, the pending separator and the kept-byte flag.
  logic [1:0][7:0] win_byte;
  logic [1:0]      win_fill;
  logic [1:0]      skip_left;
  logic            sep_pending;
  logic            any_kept;

  ucjk_pkg::out_item_t step_res[$];     // results of the byte being predicted
  ucjk_pkg::out_item_t cleaned_q[$];    // cleaned-text results still owed by the block
  stim_row_t           dir_tab[$];
  ucjk_pkg::in_item_t  rand_items[$];
  stim_row_t           cur_row;         // row now on the input channel
  ucjk_pkg::out_item_t head_item;

  int errors;
  int idle_cycles;

  // Handshake between the sender and receiver processes.
  bit quiet;       // last part of the run: no idling on either side
  bit no_gap;      // sender offers back to back (during the hold-off)
  bit hold_req;    // sender asks the receiver for its long hold-off
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic bit is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic bit is_cjk_char(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return a >= ucjk_pkg::CjkLeadLo && a <= ucjk_pkg::CjkLeadHi &&
           (b & ucjk_pkg::ContMask) == ucjk_pkg::ContTag &&
           (c & ucjk_pkg::ContMask) == ucjk_pkg::ContTag;
  endfunction

  // The four CJK punctuation ranges, all three bytes long.
  function automatic bit is_cjk_sep(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return (a == ucjk_pkg::PunctLeadE3 && b == ucjk_pkg::PunctMid80 &&
            c >= ucjk_pkg::PunctLo80 && c <= ucjk_pkg::PunctHiBf) ||
           (a == ucjk_pkg::PunctLeadEf && b == ucjk_pkg::PunctMidBc &&
            c >= ucjk_pkg::PunctLo80 && c <= ucjk_pkg::PunctHiBf) ||
           (a == ucjk_pkg::PunctLeadE2 && b == ucjk_pkg::PunctMid80 &&
            c >= ucjk_pkg::PunctLo90 && c <= ucjk_pkg::PunctHiBf) ||
           (a == ucjk_pkg::PunctLeadEf && b == ucjk_pkg::PunctMidB8 &&
            c >= ucjk_pkg::PunctLoB0 && c <= ucjk_pkg::PunctHiBf);
  endfunction

  task automatic clear_cleaner();
    win_byte    = '0;
    win_fill    = '0;
    skip_left   = '0;
    sep_pending = 1'b0;
    any_kept    = 1'b0;
  endtask

  task automatic put_result(input logic [7:0] b, input logic bv, input logic td);
    ucjk_pkg::out_item_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.text_done   = td;
    r.last_of_run = 1'b0;
    step_res.insert(step_res.size(), r);
  endtask

  // A kept byte first flushes a pending separator as one space.
  task automatic keep_byte(input logic [7:0] b);
    if (sep_pending) begin
      put_result(ucjk_pkg::SpaceByte, 1'b1, 1'b0);
      sep_pending = 1'b0;
    end
    put_result(b, 1'b1, 1'b0);
    any_kept = 1'b1;
  endtask

  // One position. full = 0 for a tail position: only one-byte classes apply.
  // Separators before the first kept byte are dropped.
  task automatic classify_pos(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input bit full);
    if (skip_left != 2'd0) begin
      skip_left = skip_left - 2'd1;
    end else if (full && is_cjk_char(a, b, c)) begin
      keep_byte(a);
      keep_byte(b);
      keep_byte(c);
      skip_left = 2'd2;
    end else if (is_alnum(a)) begin
      keep_byte(a);
    end else if (full && is_cjk_sep(a, b, c)) begin
      if (any_kept) sep_pending = 1'b1;
      skip_left = 2'd2;
    end else if (is_punct(a)) begin
      if (any_kept) sep_pending = 1'b1;
    end
  endtask

  // Results caused by one accepted input transaction, left in step_res.
  task automatic predict_clean(input ucjk_pkg::in_item_t it);
    int i;
    int last_idx;
    ucjk_pkg::out_item_t tail;
    step_res.delete();
    if (win_fill >= 2'd2) begin
      classify_pos(win_byte[0], win_byte[1], it.data_byte, 1'b1);
      win_byte[0] = win_byte[1];
      win_byte[1] = it.data_byte;
    end else begin
      win_byte[win_fill[0]] = it.data_byte;
      win_fill = win_fill + 2'd1;
    end
    if (it.end_of_text) begin
      // short tail, then the terminator; any pending space is lost
      for (i = 0; i < win_fill; i++)
        classify_pos(win_byte[i], 8'h00, 8'h00, 1'b0);
      put_result(8'h00, 1'b0, 1'b1);
      clear_cleaner();
    end
    if (step_res.size() > 0) begin
      last_idx = step_res.size() - 1;
      tail = step_res[last_idx];
      tail.last_of_run = 1'b1;
      step_res[last_idx] = tail;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  function automatic stim_row_t tab_row(logic [7:0] d, logic eot, logic hand,
                                        logic one, ucjk_pkg::out_item_t r);
    stim_row_t s;
    s.item.data_byte   = d;
    s.item.end_of_text = eot;
    s.hand_typed       = hand;
    s.one_res          = one;
    s.res              = r;
    return s;
  endfunction

  task automatic tab_add(input stim_row_t s);
    dir_tab.insert(dir_tab.size(), s);
  endtask

  task automatic rand_push(input logic [7:0] b);
    ucjk_pkg::in_item_t t;
    t.data_byte   = b;
    t.end_of_text = 1'b0;
    rand_items.insert(rand_items.size(), t);
  endtask

  // One random text: mostly well-formed tokens, with noise bytes and
  // broken CJK sequences mixed in. end_of_text goes on its last byte.
  task automatic add_text();
    int ntok;
    int k;
    int kind;
    int last_idx;
    ucjk_pkg::in_item_t last_one;
    ntok = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 10));
    for (k = 0; k < ntok; k++) begin
      kind = int'($urandom_range(0, 99));
      if (kind < 30) begin
        rand_push(8'($urandom_range(ucjk_pkg::CjkLeadLo, ucjk_pkg::CjkLeadHi)));
        rand_push(ucjk_pkg::ContTag | 8'($urandom_range(0, 63)));
        rand_push(ucjk_pkg::ContTag | 8'($urandom_range(0, 63)));
      end else if (kind < 55) begin
        case ($urandom_range(0, 2))
          0:       rand_push(8'($urandom_range(8'h30, 8'h39)));
          1:       rand_push(8'($urandom_range(8'h41, 8'h5A)));
          default: rand_push(8'($urandom_range(8'h61, 8'h7A)));
        endcase
      end else if (kind < 67) begin
        case ($urandom_range(0, 3))
          0:       rand_push(8'($urandom_range(8'h21, 8'h2F)));
          1:       rand_push(8'($urandom_range(8'h3A, 8'h40)));
          2:       rand_push(8'($urandom_range(8'h5B, 8'h60)));
          default: rand_push(8'($urandom_range(8'h7B, 8'h7E)));
        endcase
      end else if (kind < 79) begin
        case ($urandom_range(0, 3))
          0: begin
            rand_push(ucjk_pkg::PunctLeadE3); rand_push(ucjk_pkg::PunctMid80);
            rand_push(8'($urandom_range(ucjk_pkg::PunctLo80, ucjk_pkg::PunctHiBf)));
          end
          1: begin
            rand_push(ucjk_pkg::PunctLeadEf); rand_push(ucjk_pkg::PunctMidBc);
            rand_push(8'($urandom_range(ucjk_pkg::PunctLo80, ucjk_pkg::PunctHiBf)));
          end
          2: begin
            rand_push(ucjk_pkg::PunctLeadE2); rand_push(ucjk_pkg::PunctMid80);
            rand_push(8'($urandom_range(ucjk_pkg::PunctLo90, ucjk_pkg::PunctHiBf)));
          end
          default: begin
            rand_push(ucjk_pkg::PunctLeadEf); rand_push(ucjk_pkg::PunctMidB8);
            rand_push(8'($urandom_range(ucjk_pkg::PunctLoB0, ucjk_pkg::PunctHiBf)));
          end
        endcase
      end else if (kind < 90) begin
        rand_push(8'($urandom_range(0, 255)));
      end else begin
        // lead and one continuation, then a byte that is not 10xxxxxx
        rand_push(8'($urandom_range(ucjk_pkg::CjkLeadLo, ucjk_pkg::CjkLeadHi)));
        rand_push(ucjk_pkg::ContTag | 8'($urandom_range(0, 63)));
        rand_push(8'($urandom_range(0, 127)));
      end
    end
    last_idx = rand_items.size() - 1;
    last_one = rand_items[last_idx];
    last_one.end_of_text = 1'b1;
    rand_items[last_idx] = last_one;
  endtask

  // Offer one row on the input channel and hold it until the transaction
  // completes. Entered and left at a falling edge.
  task automatic send_row(input stim_row_t r);
    int gap;
    if (!quiet && !no_gap && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      gap = int'($urandom_range(1, 17));
      repeat (gap) @(negedge clk);
    end
    cur_row  = r;
    in_data  = r.item;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sender: reset, directed table, random texts, then drain and report.
  // ---------------------------------------------------------------------
  initial begin : sender
    int idx;
    stim_row_t r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cur_row  = '0;
    errors   = 0;
    quiet    = 1'b0;
    no_gap   = 1'b0;
    hold_req = 1'b0;
    clear_cleaner();

    // Directed table: extremes, every byte class, each CJK punctuation
    // range, window filling, short tail and a dropped pending space.
    tab_add(tab_row(8'h00, 1'b1, 1'b1, 1'b1, TermOnly)); // empty text
    tab_add(tab_row(8'hFF, 1'b1, 1'b1, 1'b1, TermOnly)); // top byte dropped
    tab_add(tab_row(8'h21, 1'b1, 1'b1, 1'b1, TermOnly)); // lone separator
    tab_add(tab_row(8'h41, 1'b0, 1'b1, 1'b0, NoResult)); // window filling
    tab_add(tab_row(8'hE4, 1'b0, 1'b1, 1'b0, NoResult));
    tab_add(tab_row(8'hB8, 1'b0, 1'b0, 1'b0, NoResult)); // 'A' kept
    tab_add(tab_row(8'hAD, 1'b0, 1'b0, 1'b0, NoResult)); // CJK char
    tab_add(tab_row(8'hE3, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h80, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h80, 1'b0, 1'b0, 1'b0, NoResult)); // E3 80 80 sep
    tab_add(tab_row(8'h7A, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h2C, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h30, 1'b0, 1'b0, 1'b0, NoResult)); // space + 'z'
    tab_add(tab_row(8'hEF, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'hBC, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h81, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'hE2, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h80, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h94, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'hEF, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'hB8, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'hB0, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h39, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h5A, 1'b0, 1'b0, 1'b0, NoResult));
    tab_add(tab_row(8'h2E, 1'b1, 1'b0, 1'b0, NoResult)); // tail, space lost

    while (rand_items.size() < RandBytes) add_text();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (idx = 0; idx < dir_tab.size(); idx++) send_row(dir_tab[idx]);

    for (idx = 0; idx < rand_items.size(); idx++) begin
      // Long output hold-off while the input keeps offering: the queue
      // fills and in_stall must rise.
      if (idx == 40) begin
        hold_req = 1'b1;
        no_gap   = 1'b1;
      end
      if (idx == 70) no_gap = 1'b0;
      // Sender pause until every owed result has come out.
      if (idx == 130) begin
        in_valid = 1'b0;
        while (cleaned_q.size() != 0) @(negedge clk);
      end
      if (idx >= rand_items.size() - 40) quiet = 1'b1;
      r.item       = rand_items[idx];
      r.hand_typed = 1'b0;
      r.one_res    = 1'b0;
      r.res        = NoResult;
      send_row(r);
    end
    in_valid = 1'b0;

    // Drain; the watchdog ends the run if results stop coming.
    while (cleaned_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none in
  // the last part of the run.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int burst;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = int'($urandom_range(1, 17));
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each output transaction with the oldest owed result,
  // then predict the results of an input transaction at the same edge
  // (they cannot appear before the next edge).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (cleaned_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %s",
                   $time, $sformatf("byte=%h valid=%b done=%b last=%b",
                   out_data.out_byte, out_data.byte_valid, out_data.text_done,
                   out_data.last_of_run));
          errors++;
        end else begin
          head_item = cleaned_q.pop_front();
          if (out_data !== head_item) begin
            $display("%0t: result mismatch: expected %s, actual %s", $time,
                     $sformatf("byte=%h valid=%b done=%b last=%b",
                               head_item.out_byte, head_item.byte_valid,
                               head_item.text_done, head_item.last_of_run),
                     $sformatf("byte=%h valid=%b done=%b last=%b",
                               out_data.out_byte, out_data.byte_valid,
                               out_data.text_done, out_data.last_of_run));
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_clean(in_data);
        if (cur_row.hand_typed) begin
          // hand-typed row: predictor only advances its state
          if (cur_row.one_res) cleaned_q.insert(cleaned_q.size(), cur_row.res);
        end else begin
          foreach (step_res[i]) cleaned_q.insert(cleaned_q.size(), step_res[i]);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results still owed",
                 $time, idle_cycles, cleaned_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

// ----- utf8_cjk_text_cleaner.f -----
+incdir+src
src/ucjk_pkg.sv
src/ucjk_front.sv
src/ucjk_queue.sv
src/ucjk_back.sv
src/utf8_cjk_text_cleaner.sv
tb/sv/tb_top.sv
